// ===== rtl/rhp_pkg.sv =====
// ----------------------------------------------------------------------------
// RTP header parser package
// Shared types and constants for the fixed RTP header parser.
// ----------------------------------------------------------------------------
package rhp_pkg;

  // Largest number of bytes counted in one packet; later bytes only flag overflow.
  localparam logic [15:0] MaxPacketBytes = 16'd65535;

  // Fixed header length in bytes.
  localparam logic [6:0]  FixedHdrBytes  = 7'd12;

  // Version value accepted by the parser.
  localparam logic [1:0]  RtpVersion     = 2'd2;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QueueDepth     = 4;
  localparam int unsigned QueuePtrW      = $clog2(QueueDepth);

  // Record kinds on the output.
  typedef enum logic [1:0] {
    KindHeader = 2'd0,
    KindCsrc   = 2'd1,
    KindEnd    = 2'd2
  } kind_e;

  // End record status codes.
  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusTooShort = 2'd1,
    StatusBadVer   = 2'd2,
    StatusTooLong  = 2'd3
  } status_e;

  // Work for the back part caused by one input beat: an optional header or
  // CSRC record, then an optional end record.
  typedef struct packed {
    logic        has_rec;
    logic        rec_is_csrc;
    logic        has_end;
    logic        marker;
    logic [6:0]  media_type;
    logic [15:0] seq_num;
    logic [31:0] timestamp;
    logic [31:0] ssrc;
    logic [3:0]  csrc_cnt;
    logic [31:0] csrc_word;
    status_e     status;
    logic [15:0] payload_offset;
    logic [15:0] payload_bytes;
  } entry_t;

endpackage

// ===== rtl/rtp_header_parser.sv =====
// ----------------------------------------------------------------------------
// RTP header parser
// Streaming parser for the fixed RTP header, CSRC list and end status.
// ----------------------------------------------------------------------------
// The block takes one packet byte per beat and accepts a byte every cycle
// while the queue is not full. The front part updates the byte counter and
// header capture in the cycle a byte is accepted and queues the records it
// causes in a four-entry queue; the back part sends one record per cycle,
// while the output is not stalled, through an output register. A record
// caused by a byte goes through the queue and then the output register;
// the final byte of a packet can cause two records. The input stalls only
// while the queue is full.
module rtp_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_packet_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic        marker_o,
  output logic [6:0]  media_type_o,
  output logic [15:0] seq_num_o,
  output logic [31:0] timestamp_o,
  output logic [31:0] ssrc_o,
  output logic [3:0]  csrc_cnt_o,
  output logic [31:0] csrc_word_o,
  output logic [1:0]  status_o,
  output logic [15:0] payload_offset_o,
  output logic [15:0] payload_bytes_o,
  output logic        run_last_o
);
  import rhp_pkg::*;

  logic   accept;
  logic   push;
  logic   pop;
  logic   empty;
  logic   full;
  entry_t push_entry;
  entry_t head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  rhp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .end_of_packet_i (end_of_packet_i),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  rhp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (empty),
    .full_o       (full)
  );

  rhp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_i            (head),
    .empty_i           (empty),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .kind_o            (kind_o),
    .marker_o          (marker_o),
    .media_type_o      (media_type_o),
    .seq_num_o         (seq_num_o),
    .timestamp_o       (timestamp_o),
    .ssrc_o            (ssrc_o),
    .csrc_cnt_o        (csrc_cnt_o),
    .csrc_word_o       (csrc_word_o),
    .status_o          (status_o),
    .payload_offset_o  (payload_offset_o),
    .payload_bytes_o   (payload_bytes_o),
    .run_last_o        (run_last_o)
  );

endmodule

// ===== rtl/rhp_front.sv =====
// ----------------------------------------------------------------------------
// RTP header parser front part
// Counts packet bytes, captures header fields, and classifies each beat into
// the records it causes.
// ----------------------------------------------------------------------------
module rhp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      data_byte_i,
  input  logic            end_of_packet_i,
  output logic            push_o,
  output rhp_pkg::entry_t entry_o
);
  import rhp_pkg::*;

  logic [15:0] count_q, count_d;
  logic [7:0]  hdr_q [11];
  logic [23:0] shift_q, shift_d;
  logic [7:0]  ext_hi_q, ext_hi_d;
  logic [18:0] hx_q, hx_d;
  logic        ext_known_q, ext_known_d;
  logic        ovf_q, ovf_d;

  logic        ovf;
  logic [7:0]  hdr0;
  logic [6:0]  h_bytes;
  logic        x_bit;
  logic        ver_ok;
  logic [15:0] len;
  logic [7:0]  pad;
  logic        sets_ext;
  logic [15:0] words;
  logic [18:0] base;
  logic [18:0] total;
  logic [18:0] plen_wide;
  entry_t      ent;

  // Decode the current beat against the per-packet state.
  always_comb begin
    ovf      = ovf_q || (count_q >= MaxPacketBytes);
    hdr0     = hdr_q[0];
    h_bytes  = FixedHdrBytes + {1'b0, hdr0[3:0], 2'b00};
    x_bit    = hdr0[4];
    ver_ok   = (hdr0[7:6] == RtpVersion);
    len      = ovf ? count_q : count_q + 16'd1;
    pad      = hdr0[5] ? data_byte_i : 8'd0;
    sets_ext = !ovf && x_bit && (count_q == {9'd0, h_bytes} + 16'd3);
    words    = {ext_hi_q, data_byte_i};
    base     = (x_bit && ext_known_q) ? hx_q : {12'd0, h_bytes};
    total    = base + {11'd0, pad};
    plen_wide = {3'd0, len} - total;

    count_d     = ovf ? count_q : count_q + 16'd1;
    shift_d     = ovf ? shift_q : {shift_q[15:0], data_byte_i};
    ovf_d       = ovf;
    ext_hi_d    = ext_hi_q;
    ext_known_d = ext_known_q;
    hx_d        = hx_q;

    // Extension header length, captured as its two length bytes arrive.
    if (!ovf && x_bit && (count_q == {9'd0, h_bytes} + 16'd2)) begin
      ext_hi_d = data_byte_i;
    end
    if (sets_ext) begin
      ext_known_d = 1'b1;
      hx_d        = {12'd0, h_bytes} + 19'd4 + {1'b0, words, 2'b00};
    end

    ent                 = '0;
    ent.status          = StatusOk;

    // Header record on the last fixed header byte.
    if (!ovf && (count_q == 16'd11) && ver_ok) begin
      ent.has_rec         = 1'b1;
      ent.marker          = hdr_q[1][7];
      ent.media_type      = hdr_q[1][6:0];
      ent.seq_num         = {hdr_q[2], hdr_q[3]};
      ent.timestamp       = {hdr_q[4], hdr_q[5], hdr_q[6], hdr_q[7]};
      ent.ssrc            = {hdr_q[8], hdr_q[9], hdr_q[10], data_byte_i};
      ent.csrc_cnt        = hdr0[3:0];
    end

    // CSRC record on the fourth byte of each listed source.
    if (!ovf && (count_q >= 16'd12) && (count_q < {9'd0, h_bytes}) &&
        (count_q[1:0] == 2'd3) && ver_ok) begin
      ent.has_rec     = 1'b1;
      ent.rec_is_csrc = 1'b1;
      ent.csrc_word   = {shift_q, data_byte_i};
    end

    // End record with status, offset and length.
    if (end_of_packet_i) begin
      ent.has_end = 1'b1;
      if (len < 16'd12) begin
        ent.status = StatusTooShort;
      end else if (!ver_ok) begin
        ent.status = StatusBadVer;
      end else if (ovf) begin
        ent.status = StatusTooLong;
      end else if (len < {9'd0, h_bytes}) begin
        ent.status = StatusTooShort;
      end else if (x_bit && (len < {9'd0, h_bytes} + 16'd4)) begin
        ent.status = StatusTooShort;
      end else if (sets_ext) begin
        // The extension length arrives on the final beat: the packet ends
        // right after the extension header.
        if ((words == 16'd0) && (pad == 8'd0)) begin
          ent.payload_offset = {9'd0, h_bytes} + 16'd4;
        end else begin
          ent.status = StatusTooShort;
        end
      end else if ({3'd0, len} < total) begin
        ent.status = StatusTooShort;
      end else begin
        ent.payload_offset = base[15:0];
        ent.payload_bytes  = plen_wide[15:0];
      end

      // Per-packet state returns to its reset values.
      count_d     = '0;
      shift_d     = '0;
      ext_hi_d    = '0;
      ext_known_d = 1'b0;
      hx_d        = '0;
      ovf_d       = 1'b0;
    end
  end

  assign entry_o = ent;
  assign push_o  = accept_i && (ent.has_rec || ent.has_end);

  // Per-packet control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      shift_q     <= '0;
      ext_hi_q    <= '0;
      ext_known_q <= 1'b0;
      hx_q        <= '0;
      ovf_q       <= 1'b0;
    end else if (accept_i) begin
      count_q     <= count_d;
      shift_q     <= shift_d;
      ext_hi_q    <= ext_hi_d;
      ext_known_q <= ext_known_d;
      hx_q        <= hx_d;
      ovf_q       <= ovf_d;
    end
  end

  // Header byte capture; the last header byte is used straight from the input.
  always_ff @(posedge clk_i) begin
    if (accept_i && !ovf && (count_q < 16'd11)) begin
      hdr_q[count_q[3:0]] <= data_byte_i;
    end
  end

endmodule

// ===== rtl/rhp_fifo.sv =====
// ----------------------------------------------------------------------------
// RTP header parser queue
// Short queue of record work between the front and back parts.
// ----------------------------------------------------------------------------
module rhp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rhp_pkg::entry_t push_entry_i,
  input  logic            pop_i,
  output rhp_pkg::entry_t head_o,
  output logic            empty_o,
  output logic            full_o
);
  import rhp_pkg::*;

  entry_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q;
  logic [QueuePtrW-1:0]   rd_ptr_q;
  logic [QueuePtrW:0]     count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (QueuePtrW + 1)'(QueueDepth));
  assign head_o  = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== rtl/rhp_back.sv =====
// ----------------------------------------------------------------------------
// RTP header parser back part
// Turns queued work into output records held in an output register.
// ----------------------------------------------------------------------------
module rhp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rhp_pkg::entry_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      kind_o,
  output logic            marker_o,
  output logic [6:0]      media_type_o,
  output logic [15:0]     seq_num_o,
  output logic [31:0]     timestamp_o,
  output logic [31:0]     ssrc_o,
  output logic [3:0]      csrc_cnt_o,
  output logic [31:0]     csrc_word_o,
  output logic [1:0]      status_o,
  output logic [15:0]     payload_offset_o,
  output logic [15:0]     payload_bytes_o,
  output logic            run_last_o
);
  import rhp_pkg::*;

  logic        valid_q, valid_d;
  logic        first_done_q, first_done_d;
  logic        load;
  kind_e       kind_q, kind_d;
  logic        marker_q, marker_d;
  logic [6:0]  pt_q, pt_d;
  logic [15:0] seq_q, seq_d;
  logic [31:0] ts_q, ts_d;
  logic [31:0] ssrc_q, ssrc_d;
  logic [3:0]  cc_q, cc_d;
  logic [31:0] csrc_q, csrc_d;
  status_e     status_q, status_d;
  logic [15:0] off_q, off_d;
  logic [15:0] len_q, len_d;
  logic        last_q, last_d;

  assign load = !valid_q || !out_stall_i;

  // Choose the next record from the head entry.
  always_comb begin
    valid_d      = valid_q;
    first_done_d = first_done_q;
    pop_o        = 1'b0;
    kind_d       = kind_q;
    marker_d     = marker_q;
    pt_d         = pt_q;
    seq_d        = seq_q;
    ts_d         = ts_q;
    ssrc_d       = ssrc_q;
    cc_d         = cc_q;
    csrc_d       = csrc_q;
    status_d     = status_q;
    off_d        = off_q;
    len_d        = len_q;
    last_d       = last_q;
    if (load) begin
      valid_d  = !empty_i;
      marker_d = 1'b0;
      pt_d     = '0;
      seq_d    = '0;
      ts_d     = '0;
      ssrc_d   = '0;
      cc_d     = '0;
      csrc_d   = '0;
      status_d = StatusOk;
      off_d    = '0;
      len_d    = '0;
      kind_d   = KindEnd;
      last_d   = 1'b1;
      if (!empty_i) begin
        if (head_i.has_rec && !first_done_q) begin
          // Header or CSRC record first.
          last_d = !head_i.has_end;
          if (head_i.rec_is_csrc) begin
            kind_d = KindCsrc;
            csrc_d = head_i.csrc_word;
          end else begin
            kind_d   = KindHeader;
            marker_d = head_i.marker;
            pt_d     = head_i.media_type;
            seq_d    = head_i.seq_num;
            ts_d     = head_i.timestamp;
            ssrc_d   = head_i.ssrc;
            cc_d     = head_i.csrc_cnt;
          end
          if (head_i.has_end) begin
            first_done_d = 1'b1;
          end else begin
            pop_o = 1'b1;
          end
        end else begin
          // End record closes the entry.
          status_d     = head_i.status;
          off_d        = head_i.payload_offset;
          len_d        = head_i.payload_bytes;
          first_done_d = 1'b0;
          pop_o        = 1'b1;
        end
      end
    end
  end

  // Output control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      first_done_q <= 1'b0;
    end else begin
      valid_q      <= valid_d;
      first_done_q <= first_done_d;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    marker_q <= marker_d;
    pt_q     <= pt_d;
    seq_q    <= seq_d;
    ts_q     <= ts_d;
    ssrc_q   <= ssrc_d;
    cc_q     <= cc_d;
    csrc_q   <= csrc_d;
    status_q <= status_d;
    off_q    <= off_d;
    len_q    <= len_d;
    last_q   <= last_d;
  end

  assign out_valid_o       = valid_q;
  assign kind_o            = kind_q;
  assign marker_o          = marker_q;
  assign media_type_o      = pt_q;
  assign seq_num_o         = seq_q;
  assign timestamp_o       = ts_q;
  assign ssrc_o            = ssrc_q;
  assign csrc_cnt_o        = cc_q;
  assign csrc_word_o       = csrc_q;
  assign status_o          = status_q;
  assign payload_offset_o  = off_q;
  assign payload_bytes_o   = len_q;
  assign run_last_o        = last_q;

endmodule

// ===== rtl/rhp_checker.sv =====
// ----------------------------------------------------------------------------
// RTP header parser checker
// Port-level checks on the output records of the parser.
// ----------------------------------------------------------------------------
module rhp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic        marker_o,
  input logic [6:0]  media_type_o,
  input logic [15:0] seq_num_o,
  input logic [31:0] timestamp_o,
  input logic [31:0] ssrc_o,
  input logic [3:0]  csrc_cnt_o,
  input logic [31:0] csrc_word_o,
  input logic [1:0]  status_o,
  input logic [15:0] payload_offset_o,
  input logic [15:0] payload_bytes_o,
  input logic        run_last_o
);
  import rhp_pkg::*;

  // A stalled output beat holds its record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(run_last_o) && $stable(csrc_word_o) && $stable(marker_o) &&
      $stable(media_type_o) && $stable(seq_num_o) && $stable(timestamp_o) &&
      $stable(ssrc_o) && $stable(csrc_cnt_o) && $stable(status_o) &&
      $stable(payload_offset_o) && $stable(payload_bytes_o))
    else $error("stalled output beat changed");

  // An end record is always the last record of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KindEnd) |-> run_last_o)
    else $error("end record without run_last");

  // Only end records carry status and payload position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KindEnd) |->
      (status_o == StatusOk) && (payload_offset_o == '0) && (payload_bytes_o == '0))
    else $error("status fields set outside an end record");

  // A failed packet reports no payload position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KindEnd) && (status_o != StatusOk) |->
      (payload_offset_o == '0) && (payload_bytes_o == '0))
    else $error("payload position given for a failed packet");

endmodule

bind rtp_header_parser rhp_checker u_rhp_checker (.*);
